FILE: hdl/sbalu_pkg.sv
package sbalu_pkg;

   localparam int unsigned REG_COUNT_DEF = 8;
   localparam int unsigned PC_WIDTH_DEF  = 16;
   localparam int unsigned DATA_W        = 8;
   // The exact result of any operation fits in 17 signed bits.
   localparam int unsigned WIDE_W        = 17;
   localparam int unsigned STEPS         = 8;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_INC   = 3'd3,
      OP_DEC   = 3'd4,
      OP_CLEAR = 3'd5,
      OP_DIV   = 3'd6,
      OP_NOP   = 3'd7
   } op_type;

   typedef struct packed {
      op_type     mode;
      logic [2:0] dest_index;
      logic [2:0] src_index;
   } req_type;

   typedef struct packed {
      logic signed [7:0] written_value;
      logic              zero_flag;
      logic              overflow_flag;
      logic              underflow_flag;
      logic              carry_flag;
      logic              divide_error;
      logic [15:0]       next_pc;
   } rsp_type;

   typedef struct packed {
      logic zero;
      logic over;
      logic under;
      logic carry;
   } flags_type;

   typedef struct packed {
      logic   start;
      op_type mode;
   } ex_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ex_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_SINGLE,
      EX_MUL,
      EX_DIV,
      EX_SIGN,
      EX_DONE
   } ex_state_type;

   // Register numbers are taken modulo the register count; the number is
   // below eight, so a few conditional subtractions are enough.
   function automatic logic [3:0] wrap_index(input logic [2:0] idx,
                                             input int unsigned count);
      logic [4:0] v;
      v = {2'b00, idx};
      for (int i = 0; i < 4; i++) begin
         if (v >= 5'(count)) begin
            v = v - 5'(count);
         end
      end
      return v[3:0];
   endfunction

endpackage

FILE: hdl/sbalu_regfile.sv
module sbalu_regfile #(
   parameter int unsigned REG_COUNT = sbalu_pkg::REG_COUNT_DEF,
   parameter int unsigned IDX_W     = $clog2(REG_COUNT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [sbalu_pkg::DATA_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [sbalu_pkg::DATA_W-1:0] wr_data
);

   logic [sbalu_pkg::DATA_W-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0]         valid_ff;
   logic [REG_COUNT-1:0]         valid_in;
   logic [sbalu_pkg::DATA_W-1:0] rd_data_ff;

   // An entry not written since reset reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sbalu_exec.sv
module sbalu_exec (
   input  logic                                clock,
   input  logic                                reset,
   input  sbalu_pkg::ex_cmd_type               ex_cmd,
   input  logic [sbalu_pkg::DATA_W-1:0]        opa,
   input  logic [sbalu_pkg::DATA_W-1:0]        opb,
   output sbalu_pkg::ex_stat_type              ex_stat,
   output logic signed [sbalu_pkg::WIDE_W-1:0] wide
);

   localparam int unsigned W  = sbalu_pkg::WIDE_W;
   localparam int unsigned DW = sbalu_pkg::DATA_W;

   sbalu_pkg::ex_state_type state_ff, state_in;
   logic [W-1:0]            acc_ff, acc_in;
   logic [W-1:0]            arg_ff, arg_in;
   logic [DW-1:0]           mq_ff, mq_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic                    sub_ff, sub_in;
   logic                    div_ff, div_in;

   logic [W-1:0]  add_x;
   logic [W-1:0]  add_y;
   logic          add_sub;
   logic [W-1:0]  sum;
   logic [DW-1:0] mag_a;
   logic [DW-1:0] mag_b;
   logic [W-1:0]  sext_a;
   logic [W-1:0]  sext_b;
   logic [W-1:0]  trial_x;

   // The one shared adder; subtraction by inverting the second operand.
   assign sum = add_x + (add_y ^ {W{add_sub}}) + {{(W-1){1'b0}}, add_sub};

   assign mag_a  = opa[DW-1] ? (~opa + 1'b1) : opa;
   assign mag_b  = opb[DW-1] ? (~opb + 1'b1) : opb;
   assign sext_a = {{(W-DW){opa[DW-1]}}, opa};
   assign sext_b = {{(W-DW){opb[DW-1]}}, opb};
   // Partial remainder shifted left with the next dividend bit brought in.
   assign trial_x = {{(W-DW-1){1'b0}}, acc_ff[DW-1:0], mq_ff[DW-1]};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      arg_in   = arg_ff;
      mq_in    = mq_ff;
      cnt_in   = cnt_ff;
      sub_in   = sub_ff;
      div_in   = div_ff;
      add_x    = acc_ff;
      add_y    = arg_ff;
      add_sub  = sub_ff;
      case (state_ff)
         sbalu_pkg::EX_IDLE: begin
            if (ex_cmd.start) begin
               cnt_in = '0;
               div_in = 1'b0;
               case (ex_cmd.mode)
                  sbalu_pkg::OP_ADD: begin
                     acc_in   = sext_a;
                     arg_in   = sext_b;
                     sub_in   = 1'b0;
                     state_in = sbalu_pkg::EX_SINGLE;
                  end
                  sbalu_pkg::OP_SUB: begin
                     acc_in   = sext_a;
                     arg_in   = sext_b;
                     sub_in   = 1'b1;
                     state_in = sbalu_pkg::EX_SINGLE;
                  end
                  sbalu_pkg::OP_INC: begin
                     acc_in   = sext_a;
                     arg_in   = W'(1);
                     sub_in   = 1'b0;
                     state_in = sbalu_pkg::EX_SINGLE;
                  end
                  sbalu_pkg::OP_DEC: begin
                     acc_in   = sext_a;
                     arg_in   = W'(1);
                     sub_in   = 1'b1;
                     state_in = sbalu_pkg::EX_SINGLE;
                  end
                  sbalu_pkg::OP_CLEAR: begin
                     acc_in   = '0;
                     arg_in   = '0;
                     sub_in   = 1'b0;
                     state_in = sbalu_pkg::EX_SINGLE;
                  end
                  sbalu_pkg::OP_MUL: begin
                     acc_in   = '0;
                     arg_in   = {{(W-DW){1'b0}}, mag_a};
                     mq_in    = mag_b;
                     sub_in   = opa[DW-1] ^ opb[DW-1];
                     state_in = sbalu_pkg::EX_MUL;
                  end
                  sbalu_pkg::OP_DIV: begin
                     acc_in   = '0;
                     arg_in   = {{(W-DW){1'b0}}, mag_b};
                     mq_in    = mag_a;
                     sub_in   = opa[DW-1] ^ opb[DW-1];
                     div_in   = 1'b1;
                     state_in = sbalu_pkg::EX_DIV;
                  end
                  default: begin
                     state_in = sbalu_pkg::EX_IDLE;
                  end
               endcase
            end
         end
         sbalu_pkg::EX_SINGLE: begin
            acc_in   = sum;
            state_in = sbalu_pkg::EX_DONE;
         end
         sbalu_pkg::EX_MUL: begin
            // Shift-and-add on magnitudes, one multiplier bit per cycle.
            add_y    = mq_ff[0] ? arg_ff : '0;
            add_sub  = 1'b0;
            acc_in   = sum;
            arg_in   = {arg_ff[W-2:0], 1'b0};
            mq_in    = {1'b0, mq_ff[DW-1:1]};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'(sbalu_pkg::STEPS - 1)) begin
               state_in = sbalu_pkg::EX_SIGN;
            end
         end
         sbalu_pkg::EX_DIV: begin
            // Restoring division: keep the trial difference when it is not
            // negative, and shift the quotient bit in behind the dividend.
            add_x   = trial_x;
            add_sub = 1'b1;
            if (sum[W-1]) begin
               acc_in = trial_x;
               mq_in  = {mq_ff[DW-2:0], 1'b0};
            end else begin
               acc_in = sum;
               mq_in  = {mq_ff[DW-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(sbalu_pkg::STEPS - 1)) begin
               state_in = sbalu_pkg::EX_SIGN;
            end
         end
         sbalu_pkg::EX_SIGN: begin
            // Apply the sign of the result: zero plus or minus the magnitude.
            add_x    = '0;
            add_y    = div_ff ? {{(W-DW){1'b0}}, mq_ff} : acc_ff;
            add_sub  = sub_ff;
            acc_in   = sum;
            state_in = sbalu_pkg::EX_DONE;
         end
         sbalu_pkg::EX_DONE: begin
            state_in = sbalu_pkg::EX_IDLE;
         end
         default: begin
            state_in = sbalu_pkg::EX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbalu_pkg::EX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      arg_ff <= arg_in;
      mq_ff  <= mq_in;
      cnt_ff <= cnt_in;
      sub_ff <= sub_in;
      div_ff <= div_in;
   end

   assign ex_stat.busy = (state_ff != sbalu_pkg::EX_IDLE);
   assign ex_stat.done = (state_ff == sbalu_pkg::EX_DONE);
   assign wide         = $signed(acc_ff);

endmodule

FILE: hdl/signed_byte_alu_with_flags_core.sv
// Signed byte ALU with flags.
// Each request transfer carries one instruction (mode, destination and source
// register numbers) for a small file of 8-bit signed registers. Each
// instruction gives exactly one response transfer with the value now held in
// the destination, the four flags, the divide error bit and the program
// counter after the instruction.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. req_stall is high while an instruction is in
// progress, so the block holds one instruction at a time.
// Add, subtract, increment, decrement and clear use the shared adder directly;
// multiply and divide take eight steps of the shared adder plus a sign step;
// the no-op mode and division by zero bypass the execution unit. A new
// request is taken the cycle after the response is loaded. Operands come
// one after the other from the single read port of the register file.
// If the receiver stalls, the response waits in its output register; the
// next instruction may still be taken and runs until its own result is ready.
// Synchronous reset clears the registers, flags and program counter at once.
module signed_byte_alu_with_flags_core #(
   parameter int unsigned REG_COUNT = sbalu_pkg::REG_COUNT_DEF,
   parameter int unsigned PC_WIDTH  = sbalu_pkg::PC_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sbalu_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sbalu_pkg::rsp_type rsp_payload
);

   localparam int unsigned IDX_W = $clog2(REG_COUNT);
   localparam int unsigned DW    = sbalu_pkg::DATA_W;
   localparam int unsigned W     = sbalu_pkg::WIDE_W;

   sbalu_pkg::ctl_state_type state_ff, state_in;
   sbalu_pkg::op_type        mode_ff, mode_in;
   logic [IDX_W-1:0]         dest_ff, dest_in;
   logic [IDX_W-1:0]         src_ff, src_in;
   logic [DW-1:0]            a_ff, a_in;
   logic                     nop_ff, nop_in;
   logic                     dz_ff, dz_in;
   sbalu_pkg::flags_type     flags_ff, flags_in;
   logic [PC_WIDTH-1:0]      pc_ff, pc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sbalu_pkg::rsp_type       rsp_ff, rsp_in;

   logic                     req_take;
   logic                     slot_free;
   logic [3:0]               dest_wrap;
   logic [3:0]               src_wrap;
   logic [IDX_W-1:0]         rf_rd_addr;
   logic [DW-1:0]            rf_rd_data;
   logic                     rf_wr_en;
   sbalu_pkg::ex_cmd_type    ex_cmd;
   sbalu_pkg::ex_stat_type   ex_stat;
   logic signed [W-1:0]      wide;
   sbalu_pkg::flags_type     wide_flags;

   assign req_stall = (state_ff != sbalu_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign dest_wrap = sbalu_pkg::wrap_index(req_payload.dest_index, REG_COUNT);
   assign src_wrap  = sbalu_pkg::wrap_index(req_payload.src_index, REG_COUNT);

   assign rf_rd_addr = (state_ff == sbalu_pkg::ST_READ_A) ? dest_ff : src_ff;
   assign rf_wr_en   = (state_ff == sbalu_pkg::ST_FINISH) && slot_free
                       && !nop_ff && !dz_ff;

   // Flags from the exact result: out of range when the bits above the low
   // seven do not all equal the sign.
   assign wide_flags.zero  = (wide == '0);
   assign wide_flags.over  = !wide[W-1] && (|wide[W-2:DW-1]);
   assign wide_flags.under = wide[W-1] && !(&wide[W-2:DW-1]);
   assign wide_flags.carry = wide_flags.over || wide_flags.under;

   sbalu_regfile #(
      .REG_COUNT (REG_COUNT),
      .IDX_W     (IDX_W)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd_data),
      .wr_en   (rf_wr_en),
      .wr_addr (dest_ff),
      .wr_data (wide[DW-1:0])
   );

   sbalu_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .ex_cmd  (ex_cmd),
      .opa     (a_ff),
      .opb     (rf_rd_data),
      .ex_stat (ex_stat),
      .wide    (wide)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      a_in         = a_ff;
      nop_in       = nop_ff;
      dz_in        = dz_ff;
      flags_in     = flags_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ex_cmd.start = 1'b0;
      ex_cmd.mode  = mode_ff;
      case (state_ff)
         sbalu_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in  = req_payload.mode;
               dest_in  = dest_wrap[IDX_W-1:0];
               src_in   = src_wrap[IDX_W-1:0];
               state_in = sbalu_pkg::ST_READ_A;
            end
         end
         sbalu_pkg::ST_READ_A: begin
            state_in = sbalu_pkg::ST_READ_B;
         end
         sbalu_pkg::ST_READ_B: begin
            a_in     = rf_rd_data;
            state_in = sbalu_pkg::ST_START;
         end
         sbalu_pkg::ST_START: begin
            nop_in = (mode_ff == sbalu_pkg::OP_NOP);
            dz_in  = (mode_ff == sbalu_pkg::OP_DIV) && (rf_rd_data == '0);
            if (nop_in || dz_in) begin
               state_in = sbalu_pkg::ST_FINISH;
            end else begin
               ex_cmd.start = 1'b1;
               state_in     = sbalu_pkg::ST_WAIT;
            end
         end
         sbalu_pkg::ST_WAIT: begin
            if (ex_stat.done) begin
               state_in = sbalu_pkg::ST_FINISH;
            end
         end
         sbalu_pkg::ST_FINISH: begin
            if (slot_free) begin
               pc_in                 = pc_ff + 1'b1;
               rsp_in.written_value  = a_ff;
               rsp_in.divide_error   = dz_ff;
               if (dz_ff) begin
                  flags_in = '0;
               end else if (!nop_ff) begin
                  flags_in             = wide_flags;
                  rsp_in.written_value = wide[DW-1:0];
               end
               rsp_in.zero_flag      = flags_in.zero;
               rsp_in.overflow_flag  = flags_in.over;
               rsp_in.underflow_flag = flags_in.under;
               rsp_in.carry_flag     = flags_in.carry;
               rsp_in.next_pc        = 16'(pc_in);
               rsp_valid_in          = 1'b1;
               state_in              = sbalu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbalu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbalu_pkg::ST_IDLE;
         flags_ff     <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      dest_ff <= dest_in;
      src_ff  <= src_in;
      a_ff    <= a_in;
      nop_ff  <= nop_in;
      dz_ff   <= dz_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      ex_stat.done |-> (state_ff == sbalu_pkg::ST_WAIT))
      else $error("execution unit finished outside the wait state");

   a_engine_idle_on_take: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !ex_stat.busy)
      else $error("instruction taken while the execution unit is busy");

   a_div_error_clears_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.divide_error) |->
         (!rsp_payload.zero_flag && !rsp_payload.overflow_flag
          && !rsp_payload.underflow_flag && !rsp_payload.carry_flag))
      else $error("flags set alongside a divide error");

   a_carry_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.carry_flag
                     == (rsp_payload.overflow_flag || rsp_payload.underflow_flag)))
      else $error("carry flag disagrees with overflow and underflow");

   a_pc_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) |=>
         (rsp_payload.next_pc == 16'(pc_ff)))
      else $error("response program counter does not match the counter");

endmodule
